>>> hw/rtl/ccrv_pkg.sv
// ----------------------------------------------------------------------------
// ccrv_pkg
// Shared types, constants and the CRC-32 word update for the record validator.
// ----------------------------------------------------------------------------
package ccrv_pkg;

  // Default number of payload words in one record.
  localparam int PAYLOAD_WORDS_DEF = 16;

  // Width of the word position counter within a record.
  localparam int POS_W = 6;

  // Header and CRC constants.
  localparam logic [31:0] REC_MAGIC   = 32'h4341_4C31;
  localparam logic [31:0] REC_VERSION = 32'h0000_0001;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Result kind codes.
  typedef enum logic {
    KIND_STATUS  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  // One command from the front to the back: the status of a finished record
  // and the payload bank that holds its words.
  typedef struct packed {
    status_t status;
    logic    bank;
  } cmd_t;

  // Reflected CRC-32 update over the four little-endian bytes of one word.
  function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < 32; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/ccrv_ram.sv
// ----------------------------------------------------------------------------
// ccrv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ccrv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/ccrv_front.sv
// ----------------------------------------------------------------------------
// ccrv_front
// Accepts record words, runs the CRC and header checks, stores the payload
// into one of two banks and hands one command per record to the queue.
// ----------------------------------------------------------------------------
module ccrv_front #(
  parameter int PAYLOAD_WORDS = ccrv_pkg::PAYLOAD_WORDS_DEF,
  parameter int AW            = $clog2(2 * PAYLOAD_WORDS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               in_start,
  input  logic               q_full,
  output logic               q_push,
  output ccrv_pkg::cmd_t     q_cmd,
  input  logic               bank_done,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [31:0]        wr_data
);
  import ccrv_pkg::*;

  localparam logic [POS_W-1:0] CRC_POS  = POS_W'(PAYLOAD_WORDS + 4);
  localparam logic [31:0]      SIZE_VAL = 32'(4 * PAYLOAD_WORDS);

  logic [31:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             header_bad_r, header_bad_nxt;
  logic             empty_r, empty_nxt;
  logic             wr_bank_r, wr_bank_nxt;
  logic [1:0]       banks_r, banks_nxt;

  logic             accept;
  logic [POS_W-1:0] p;
  logic [31:0]      crc_base;
  logic             bad_base;
  logic             is_crc;
  logic             is_pay;
  logic [POS_W-1:0] pay_idx;
  status_t          st;

  // Take a word only when the queue has room and a payload bank is free.
  assign in_tready = !q_full && (banks_r != 2'd2);
  assign accept    = in_tvalid && in_tready;

  // Position of this word, with a start mark forcing a new record.
  always_comb begin
    p        = in_start ? '0 : pos_r;
    crc_base = (p == '0) ? ALL_ONES : crc_r;
    bad_base = (p == '0) ? 1'b0 : header_bad_r;
    is_crc   = (p >= CRC_POS);
    is_pay   = (p >= POS_W'(4)) && !is_crc;
    pay_idx  = p - POS_W'(4);
  end

  // Status of a record at its CRC word; empty wins over every other check.
  always_comb begin
    if (empty_r) begin
      st = ST_EMPTY;
    end else if (header_bad_r || ((crc_r ^ ALL_ONES) != in_tdata)) begin
      st = ST_INVALID;
    end else begin
      st = ST_OK;
    end
  end

  // Per-word state update.
  always_comb begin
    crc_nxt        = crc_r;
    pos_nxt        = pos_r;
    header_bad_nxt = header_bad_r;
    empty_nxt      = empty_r;
    wr_bank_nxt    = wr_bank_r;
    q_push         = 1'b0;
    if (accept) begin
      if (p == '0) begin
        empty_nxt = (in_tdata == ALL_ONES);
      end
      if (!is_crc) begin
        header_bad_nxt = bad_base
                         || ((p == POS_W'(0)) && (in_tdata != REC_MAGIC))
                         || ((p == POS_W'(1)) && (in_tdata != REC_VERSION))
                         || ((p == POS_W'(2)) && (in_tdata != SIZE_VAL));
        crc_nxt = crc32_word(crc_base, in_tdata);
        pos_nxt = p + POS_W'(1);
      end else begin
        crc_nxt = ALL_ONES;
        pos_nxt = '0;
        q_push  = 1'b1;
        if (st == ST_OK) begin
          wr_bank_nxt = !wr_bank_r;
        end
      end
    end
  end

  assign q_cmd.status = st;
  assign q_cmd.bank   = wr_bank_r;

  // Count of banks held by records that are queued or being sent.
  always_comb begin
    banks_nxt = banks_r;
    if (q_push && (st == ST_OK) && !bank_done) begin
      banks_nxt = banks_r + 2'd1;
    end else if (!(q_push && (st == ST_OK)) && bank_done) begin
      banks_nxt = banks_r - 2'd1;
    end
  end

  // Payload write into the current bank.
  assign wr_en   = accept && is_pay;
  assign wr_addr = (wr_bank_r ? AW'(PAYLOAD_WORDS) : AW'(0)) + AW'(pay_idx);
  assign wr_data = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= ALL_ONES;
      pos_r        <= '0;
      header_bad_r <= 1'b0;
      empty_r      <= 1'b0;
      wr_bank_r    <= 1'b0;
      banks_r      <= 2'd0;
    end else begin
      crc_r        <= crc_nxt;
      pos_r        <= pos_nxt;
      header_bad_r <= header_bad_nxt;
      empty_r      <= empty_nxt;
      wr_bank_r    <= wr_bank_nxt;
      banks_r      <= banks_nxt;
    end
  end

endmodule

>>> hw/rtl/ccrv_cmd_queue.sv
// ----------------------------------------------------------------------------
// ccrv_cmd_queue
// Two-entry queue of record commands between the front and the back.
// ----------------------------------------------------------------------------
module ccrv_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccrv_pkg::cmd_t push_cmd,
  input  logic           pop,
  output ccrv_pkg::cmd_t head_cmd,
  output logic           empty,
  output logic           full
);
  import ccrv_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign head_cmd = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/ccrv_back.sv
// ----------------------------------------------------------------------------
// ccrv_back
// Takes record commands, sends the status result and, for a good record,
// reads its payload bank and sends the words through the output register.
// ----------------------------------------------------------------------------
module ccrv_back #(
  parameter int PAYLOAD_WORDS = ccrv_pkg::PAYLOAD_WORDS_DEF,
  parameter int AW            = $clog2(2 * PAYLOAD_WORDS),
  parameter int IDX_W         = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ccrv_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           bank_done,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [31:0]    rd_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import ccrv_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_WORDS - 1);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_PAY  = 2'b10
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             bank_r, bank_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [31:0]      out_pay_r, out_pay_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             rd_bank;
  logic [IDX_W-1:0] rd_idx;

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: status first, then one payload word a cycle while the output register is free.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    bank_nxt       = bank_r;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    q_pop          = 1'b0;
    bank_done      = 1'b0;
    rd_en          = 1'b0;
    rd_bank        = bank_r;
    rd_idx         = idx_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = q_head.status;
          out_pay_nxt    = '0;
          out_last_nxt   = (q_head.status != ST_OK);
          if (q_head.status == ST_OK) begin
            rd_en     = 1'b1;
            rd_bank   = q_head.bank;
            rd_idx    = '0;
            bank_nxt  = q_head.bank;
            idx_nxt   = '0;
            state_nxt = B_PAY;
          end
        end
      end
      B_PAY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_PAYLOAD;
          out_status_nxt = ST_OK;
          out_pay_nxt    = rd_data;
          out_last_nxt   = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            bank_done = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_idx  = idx_r + IDX_W'(1);
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign rd_addr = (rd_bank ? AW'(PAYLOAD_WORDS) : AW'(0)) + AW'(rd_idx);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_pay_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers need no reset.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    bank_r       <= bank_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

>>> hw/rtl/crc_checked_record_validator_core.sv
// ----------------------------------------------------------------------------
// crc_checked_record_validator_core
// Checks CRC-32 protected records word by word and releases verified payload.
// ----------------------------------------------------------------------------
// The block takes one 32-bit record word per cycle (magic, version, size,
// sequence, PAYLOAD_WORDS payload words, CRC) and answers each record with a
// status result; a good record's payload words follow, one per cycle while the
// output is ready, read from a two-bank payload RAM. A record of
// PAYLOAD_WORDS+5 words thus gives PAYLOAD_WORDS+1 results, or one result
// for an empty or invalid record. The input side stalls only while both
// payload banks are held by good records waiting to be sent or while the
// two-entry command queue is full. With the output ready, a record's results
// take fewer cycles than its words, so the input accepts one word every cycle;
// stalls on the output stream reach the input once both banks are held.
module crc_checked_record_validator_core #(
  parameter int PAYLOAD_WORDS = ccrv_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] word
  input  logic        in_tuser,   // [0] starts_record
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] payload_word, [39:34] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);
  import ccrv_pkg::*;

  localparam int DEPTH = 2 * PAYLOAD_WORDS;
  localparam int AW    = $clog2(DEPTH);

  logic          q_full, q_empty, q_push, q_pop;
  cmd_t          q_cmd, q_head;
  logic          bank_done;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;

  // Front end: checks and payload capture.
  ccrv_front #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS),
    .AW            (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_start  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .bank_done (bank_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Command queue between the two sides.
  ccrv_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Two payload banks.
  ccrv_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back end: result sequencing.
  ccrv_back #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS),
    .AW            (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .bank_done  (bank_done),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
